@@ sv/pkv_pkg.sv @@
`timescale 1ns / 1ps

package pkv_pkg;

    // Field widths of one input item and one result item.
    localparam int POS_W      = 24;
    localparam int REQ_W      = 6;
    localparam int COL_W      = 6;
    localparam int BLK_W      = 20;
    localparam int SLOT_W     = 31;

    // Configuration register widths.
    localparam int BS_W       = 11;
    localparam int WSL_W      = 2;
    localparam int RANK_W     = 3;
    localparam int ILS_W      = 2;
    localparam int IL_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Virtual block is at most 1024 tokens times 8 ranks.
    localparam int VBS_W      = 14;
    localparam int VOFF_W     = 13;

    // Stream widths.
    localparam int S_TDATA_W  = 56;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 2;

    // Block size limits and reset value.
    localparam logic [BS_W-1:0] BS_MIN   = BS_W'(1);
    localparam logic [BS_W-1:0] BS_MAX   = BS_W'(1024);
    localparam logic [BS_W-1:0] BS_RESET = BS_W'(16);

    // Interleave chunk sizes as log2: 1, 16 and 64 tokens.
    localparam logic [IL_W-1:0] IL_LOG2_1  = IL_W'(0);
    localparam logic [IL_W-1:0] IL_LOG2_16 = IL_W'(4);
    localparam logic [IL_W-1:0] IL_LOG2_64 = IL_W'(6);

    // Slot value for a token that is not mapped here.
    localparam logic [SLOT_W-1:0] PAD_SLOT = '1;

    // Queue between the front and the back; covers the front latency.
    localparam int FIFO_DEPTH = 32;

    // Defaults of the table geometry.
    localparam int MAX_REQUESTS_DEF       = 64;
    localparam int BLOCKS_PER_REQUEST_DEF = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE  = 2'd0,
        CFG_WORLD_LOG2  = 2'd1,
        CFG_RANK        = 2'd2,
        CFG_INTERLEAVE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [ILS_W-1:0] {
        IL_SEL_1  = 2'd0,
        IL_SEL_16 = 2'd1,
        IL_SEL_64 = 2'd2
    } t_il_sel;

    // Effective configuration, already clamped and decoded.
    typedef struct packed {
        logic [BS_W-1:0]   bs;
        logic [WSL_W-1:0]  ws_log2;
        logic [RANK_W-1:0] rank;
        logic [IL_W-1:0]   il_log2;
    } t_cfg;

    // One classified transaction waiting in the queue.
    typedef struct packed {
        logic              tok;
        logic              oor;
        logic              loc;
        logic              act;
        logic [BLK_W-1:0]  data;
        logic [VOFF_W-1:0] loff;
    } t_qent;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

@@ sv/pkv_front.sv @@
`timescale 1ns / 1ps

module pkv_front #(
    parameter int MAX_REQUESTS       = pkv_pkg::MAX_REQUESTS_DEF,
    parameter int BLOCKS_PER_REQUEST = pkv_pkg::BLOCKS_PER_REQUEST_DEF,
    parameter int TAB_AW             = (MAX_REQUESTS * BLOCKS_PER_REQUEST > 1)
                                     ? $clog2(MAX_REQUESTS * BLOCKS_PER_REQUEST) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pkv_pkg::t_cfg                     i_cfg,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_mode,
    input  logic [pkv_pkg::REQ_W-1:0]         i_request,
    input  logic [pkv_pkg::COL_W-1:0]         i_column,
    input  logic [pkv_pkg::BLK_W-1:0]         i_phys_block,
    input  logic [pkv_pkg::POS_W-1:0]         i_position,
    input  logic                              i_pop,
    output logic                              o_push,
    output pkv_pkg::t_qent                    o_entry,
    output logic [TAB_AW-1:0]                 o_idx
);

    localparam int NS        = pkv_pkg::POS_W;
    localparam int CNT_W     = $clog2(pkv_pkg::FIFO_DEPTH + 1);

    logic                              w_acc;
    logic [pkv_pkg::VBS_W-1:0]         w_vbs;
    logic [CNT_W-1:0]                  r_cnt;
    logic [CNT_W-1:0]                  n_cnt;

    logic                              r_v    [0:NS];
    logic [pkv_pkg::VBS_W-1:0]         r_rem  [0:NS];
    logic [pkv_pkg::POS_W-1:0]         r_q    [0:NS];
    logic [pkv_pkg::POS_W-1:0]         r_pos  [0:NS];
    logic                              r_mode [0:NS];
    logic [pkv_pkg::REQ_W-1:0]         r_req  [0:NS];
    logic [pkv_pkg::COL_W-1:0]         r_col  [0:NS];
    logic [pkv_pkg::BLK_W-1:0]         r_blk  [0:NS];

    logic [pkv_pkg::VOFF_W-1:0]        w_voff;
    logic [pkv_pkg::VOFF_W-1:0]        w_sh1;
    logic [pkv_pkg::VOFF_W-1:0]        w_hi;
    logic [pkv_pkg::VOFF_W-1:0]        w_ilmask;
    logic [pkv_pkg::RANK_W-1:0]        w_wsmask;
    logic [3:0]                        w_sh2;
    logic                              w_loc;
    logic                              w_oor;
    logic                              w_wr_ok;
    logic [31:0]                       w_colsel;

    // Credits: every transaction in the divider or the queue holds one slot,
    // so the queue can never overflow and the divider never stalls.
    assign o_ready = (r_cnt < CNT_W'(pkv_pkg::FIFO_DEPTH));
    assign w_acc   = i_valid && o_ready;
    assign n_cnt   = r_cnt + CNT_W'(w_acc) - CNT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign w_vbs = pkv_pkg::VBS_W'(i_cfg.bs) << i_cfg.ws_log2;

    // Input capture stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rem[0]  <= '0;
            r_q[0]    <= '0;
            r_pos[0]  <= i_position;
            r_mode[0] <= i_mode;
            r_req[0]  <= i_request;
            r_col[0]  <= i_column;
            r_blk[0]  <= i_phys_block;
        end
    end

    // Restoring divider, one quotient bit per stage, MSB first.
    for (genvar s = 0; s < NS; s++) begin : g_div
        logic [pkv_pkg::VBS_W:0] w_t;
        logic [pkv_pkg::VBS_W:0] w_d;
        logic                    w_ge;

        always_comb begin
            w_t  = {r_rem[s], r_pos[s][NS-1-s]};
            w_ge = (w_t >= {1'b0, w_vbs});
            w_d  = w_t - {1'b0, w_vbs};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s+1]  <= w_ge ? pkv_pkg::VBS_W'(w_d) : pkv_pkg::VBS_W'(w_t);
            r_q[s+1]    <= {r_q[s][NS-2:0], w_ge};
            r_pos[s+1]  <= r_pos[s];
            r_mode[s+1] <= r_mode[s];
            r_req[s+1]  <= r_req[s];
            r_col[s+1]  <= r_col[s];
            r_blk[s+1]  <= r_blk[s];
        end
    end

    // Classify: rank ownership, local offset, range checks and table index.
    always_comb begin
        w_voff   = r_rem[NS][pkv_pkg::VOFF_W-1:0];
        w_sh1    = w_voff >> i_cfg.il_log2;
        w_wsmask = pkv_pkg::RANK_W'((4'd1 << i_cfg.ws_log2) - 4'd1);
        w_loc    = ((w_sh1[pkv_pkg::RANK_W-1:0] & w_wsmask) == i_cfg.rank);
        w_sh2    = 4'(i_cfg.ws_log2) + 4'(i_cfg.il_log2);
        w_hi     = (w_voff >> w_sh2) << i_cfg.il_log2;
        w_ilmask = (pkv_pkg::VOFF_W'(1) << i_cfg.il_log2) - pkv_pkg::VOFF_W'(1);
        w_oor    = (32'(r_q[NS]) >= 32'(BLOCKS_PER_REQUEST))
                || (32'(r_req[NS]) >= 32'(MAX_REQUESTS));
        w_wr_ok  = (32'(r_col[NS]) < 32'(BLOCKS_PER_REQUEST))
                && (32'(r_req[NS]) < 32'(MAX_REQUESTS));
        w_colsel = r_mode[NS] ? 32'(r_q[NS]) : 32'(r_col[NS]);

        o_push        = r_v[NS];
        o_entry.tok   = r_mode[NS];
        o_entry.oor   = w_oor;
        o_entry.loc   = w_loc;
        o_entry.act   = r_mode[NS] ? (!w_oor && w_loc) : w_wr_ok;
        o_entry.data  = r_blk[NS];
        o_entry.loff  = w_hi | (w_voff & w_ilmask);
        o_idx         = TAB_AW'(32'(r_req[NS]) * 32'(BLOCKS_PER_REQUEST) + w_colsel);
    end

endmodule

@@ sv/pkv_fifo.sv @@
`timescale 1ns / 1ps

module pkv_fifo #(
    parameter int W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [W-1:0]     i_data,
    input  logic             i_pop,
    output logic [W-1:0]     o_data,
    output pkv_pkg::t_qstat  o_stat
);

    localparam int AW = $clog2(pkv_pkg::FIFO_DEPTH);

    logic [W-1:0] r_mem [0:pkv_pkg::FIFO_DEPTH-1];
    logic [AW:0]  r_wp;
    logic [AW:0]  r_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + (AW+1)'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp[AW-1:0]] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rp[AW-1:0]];
    assign o_stat.empty = (r_wp == r_rp);
    assign o_stat.full  = (r_wp[AW] != r_rp[AW]) && (r_wp[AW-1:0] == r_rp[AW-1:0]);

endmodule

@@ sv/pkv_back.sv @@
`timescale 1ns / 1ps

module pkv_back #(
    parameter int MAX_REQUESTS       = pkv_pkg::MAX_REQUESTS_DEF,
    parameter int BLOCKS_PER_REQUEST = pkv_pkg::BLOCKS_PER_REQUEST_DEF,
    parameter int TAB_AW             = (MAX_REQUESTS * BLOCKS_PER_REQUEST > 1)
                                     ? $clog2(MAX_REQUESTS * BLOCKS_PER_REQUEST) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pkv_pkg::BS_W-1:0]      i_bs,
    input  pkv_pkg::t_qstat               i_stat,
    input  pkv_pkg::t_qent                i_entry,
    input  logic [TAB_AW-1:0]             i_idx,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [pkv_pkg::SLOT_W-1:0]    o_slot,
    output logic                          o_loc,
    output logic                          o_oor
);

    localparam int TAB_DEPTH = MAX_REQUESTS * BLOCKS_PER_REQUEST;

    logic [pkv_pkg::BLK_W-1:0]  r_tab [0:TAB_DEPTH-1];
    logic [pkv_pkg::BLK_W-1:0]  r_rd;

    logic                       w_adv;
    logic                       r_v1, r_v2, r_v3;
    logic                       r_act1, r_act2;
    logic                       r_loc1, r_loc2, r_loc3;
    logic                       r_oor1, r_oor2, r_oor3;
    logic [pkv_pkg::VOFF_W-1:0] r_loff1, r_loff2;
    logic [pkv_pkg::SLOT_W-1:0] r_prod;
    logic [pkv_pkg::SLOT_W-1:0] r_slot;

    // The whole back pipeline moves together when the output can move.
    assign w_adv = !r_v3 || i_ready;
    assign o_pop = !i_stat.empty && w_adv;

    // Block table: table transactions write, token transactions read.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.act) begin
            if (i_entry.tok) begin
                r_rd <= r_tab[i_idx];
            end else begin
                r_tab[i_idx] <= i_entry.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= o_pop && i_entry.tok;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_act1  <= i_entry.act;
            r_loc1  <= i_entry.loc;
            r_oor1  <= i_entry.oor;
            r_loff1 <= i_entry.loff;

            r_prod  <= pkv_pkg::SLOT_W'(r_rd) * pkv_pkg::SLOT_W'(i_bs);
            r_act2  <= r_act1;
            r_loc2  <= r_loc1;
            r_oor2  <= r_oor1;
            r_loff2 <= r_loff1;

            r_slot  <= r_act2 ? (r_prod + pkv_pkg::SLOT_W'(r_loff2)) : pkv_pkg::PAD_SLOT;
            r_loc3  <= r_loc2;
            r_oor3  <= r_oor2;
        end
    end

    assign o_valid = r_v3;
    assign o_slot  = r_slot;
    assign o_loc   = r_loc3;
    assign o_oor   = r_oor3;

endmodule

@@ sv/paged_kv_slot_mapper_top.sv @@
`timescale 1ns / 1ps

// Paged KV-cache slot mapper. Table transactions (tuser mode 0) write one
// physical block number into the per-request block table and return nothing;
// token transactions (mode 1) return exactly one result, in input order. The
// block sustains one transaction per clock on both streams while the result
// stream is ready. A token's position is divided by the virtual block size
// (the block size times the rank count) in a 24-stage pipelined restoring
// divider, one quotient bit per stage. A transaction passes the input capture
// register and the divider stages to reach the queue; the back then passes it
// through the table read (as it leaves the queue), the multiply and the result
// register, which drives the output stream. The 32-entry queue between the
// front and the back is credit managed: s_tready falls only when 32
// transactions are in the divider or the queue, which is what keeps the rate
// at one per cycle while the output stream is drained. The block table is a
// plain memory without reset; a token must only look up entries that were
// written before. Configuration must be written only while the block is
// idle; the block itself does not enforce this. An out-of-range column or
// request gives the pad slot (all ones) with out_of_range set, and a chunk
// owned by another rank gives the pad slot with local_hit clear.
module paged_kv_slot_mapper_top #(
    parameter int MAX_REQUESTS       = pkv_pkg::MAX_REQUESTS_DEF,
    parameter int BLOCKS_PER_REQUEST = pkv_pkg::BLOCKS_PER_REQUEST_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [pkv_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pkv_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // Input stream.
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [5:0] request, [11:6] column, [31:12] phys_block, [55:32] position
    input  logic [pkv_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // [0] mode
    input  logic [pkv_pkg::S_TUSER_W-1:0]    i_s_tuser,
    // Result stream.
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [30:0] slot, [31] zero
    output logic [pkv_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // [0] local_hit, [1] out_of_range
    output logic [pkv_pkg::M_TUSER_W-1:0]    o_m_tuser
);

    localparam int TAB_DEPTH = MAX_REQUESTS * BLOCKS_PER_REQUEST;
    localparam int TAB_AW    = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
    localparam int QW        = $bits(pkv_pkg::t_qent) + TAB_AW;

    // Raw configuration registers.
    logic [pkv_pkg::BS_W-1:0]   r_bs;
    logic [pkv_pkg::WSL_W-1:0]  r_wsl;
    logic [pkv_pkg::RANK_W-1:0] r_rank;
    logic [pkv_pkg::ILS_W-1:0]  r_ils;
    pkv_pkg::t_cfg              w_cfg;

    // Front to queue to back.
    logic                       w_push;
    pkv_pkg::t_qent             w_fentry;
    logic [TAB_AW-1:0]          w_fidx;
    logic [QW-1:0]              w_qdata;
    pkv_pkg::t_qent             w_bentry;
    logic [TAB_AW-1:0]          w_bidx;
    pkv_pkg::t_qstat            w_qstat;
    logic                       w_pop;

    logic [pkv_pkg::SLOT_W-1:0] w_slot;
    logic                       w_loc;
    logic                       w_oor;

    // Register writes take effect at the clock edge where the enable is high.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs   <= pkv_pkg::BS_RESET;
            r_wsl  <= '0;
            r_rank <= '0;
            r_ils  <= '0;
        end else if (i_cfg_we) begin
            unique case (pkv_pkg::t_cfg_idx'(i_cfg_idx))
                pkv_pkg::CFG_BLOCK_SIZE: r_bs   <= i_cfg_wdata[pkv_pkg::BS_W-1:0];
                pkv_pkg::CFG_WORLD_LOG2: r_wsl  <= i_cfg_wdata[pkv_pkg::WSL_W-1:0];
                pkv_pkg::CFG_RANK:       r_rank <= i_cfg_wdata[pkv_pkg::RANK_W-1:0];
                pkv_pkg::CFG_INTERLEAVE: r_ils  <= i_cfg_wdata[pkv_pkg::ILS_W-1:0];
                default: ;
            endcase
        end
    end

    // Block size zero counts as one and anything above 1024 saturates.
    // Interleave select three falls back to the 64-token chunk.
    always_comb begin
        if (r_bs == '0) begin
            w_cfg.bs = pkv_pkg::BS_MIN;
        end else if (r_bs > pkv_pkg::BS_MAX) begin
            w_cfg.bs = pkv_pkg::BS_MAX;
        end else begin
            w_cfg.bs = r_bs;
        end
        w_cfg.ws_log2 = r_wsl;
        w_cfg.rank    = r_rank;
        unique case (pkv_pkg::t_il_sel'(r_ils))
            pkv_pkg::IL_SEL_1:  w_cfg.il_log2 = pkv_pkg::IL_LOG2_1;
            pkv_pkg::IL_SEL_16: w_cfg.il_log2 = pkv_pkg::IL_LOG2_16;
            default:            w_cfg.il_log2 = pkv_pkg::IL_LOG2_64;
        endcase
    end

    pkv_front #(
        .MAX_REQUESTS       (MAX_REQUESTS),
        .BLOCKS_PER_REQUEST (BLOCKS_PER_REQUEST),
        .TAB_AW             (TAB_AW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_valid        (i_s_tvalid),
        .o_ready        (o_s_tready),
        .i_mode         (i_s_tuser[0]),
        .i_request      (i_s_tdata[5:0]),
        .i_column       (i_s_tdata[11:6]),
        .i_phys_block   (i_s_tdata[31:12]),
        .i_position     (i_s_tdata[55:32]),
        .i_pop          (w_pop),
        .o_push         (w_push),
        .o_entry        (w_fentry),
        .o_idx          (w_fidx)
    );

    pkv_fifo #(
        .W (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_fentry, w_fidx}),
        .i_pop   (w_pop),
        .o_data  (w_qdata),
        .o_stat  (w_qstat)
    );

    assign w_bentry = pkv_pkg::t_qent'(w_qdata[QW-1:TAB_AW]);
    assign w_bidx   = w_qdata[TAB_AW-1:0];

    pkv_back #(
        .MAX_REQUESTS       (MAX_REQUESTS),
        .BLOCKS_PER_REQUEST (BLOCKS_PER_REQUEST),
        .TAB_AW             (TAB_AW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bs    (w_cfg.bs),
        .i_stat  (w_qstat),
        .i_entry (w_bentry),
        .i_idx   (w_bidx),
        .o_pop   (w_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_slot  (w_slot),
        .o_loc   (w_loc),
        .o_oor   (w_oor)
    );

    assign o_m_tdata = {1'b0, w_slot};
    assign o_m_tuser = {w_oor, w_loc};

`ifndef SYNTHESIS
    // The credit scheme must keep the queue from ever being pushed when full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("queue pushed while full");

    // A full queue means all credits are in use, so the input must stall.
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.full |-> !o_s_tready)
        else $error("input ready while queue full");

    // Foreign or out-of-range tokens always carry the pad slot.
    a_pad_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (!o_m_tuser[0] || o_m_tuser[1]))
            |-> (o_m_tdata[pkv_pkg::SLOT_W-1:0] == pkv_pkg::PAD_SLOT))
        else $error("unmapped token without pad slot");
`endif

endmodule

@@ tb/sv/paged_kv_slot_mapper_top_tb.sv @@
`timescale 1ns / 1ps

module paged_kv_slot_mapper_top_tb;
    import pkv_pkg::*;

    localparam int ROWS            = MAX_REQUESTS_DEF;
    localparam int COLS            = BLOCKS_PER_REQUEST_DEF;
    localparam int IDLE_PCT        = 19;
    localparam int DRAIN_CYCLES    = 64;       // longer than the path from input to result
    localparam int HOLD_CYCLES     = 400;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int CYCLE_LIMIT     = 200000;

    localparam logic MODE_TABLE = 1'b0;
    localparam logic MODE_TOKEN = 1'b1;

    // Select code 3 is not in the enum; the block treats it like 64 tokens.
    localparam logic [ILS_W-1:0] IL_SEL_64_ALIAS = 2'd3;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              local_hit;
        logic              oor;
    } t_slot_result;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata   = '0;
    logic [S_TUSER_W-1:0]  i_s_tuser   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic [M_TUSER_W-1:0]  o_m_tuser;

    // Shadow copy of the configuration and of the block table.
    logic [BS_W-1:0]    cfg_bs      = BS_RESET;
    logic [WSL_W-1:0]   cfg_ws_log2 = '0;
    logic [RANK_W-1:0]  cfg_rank    = '0;
    logic [ILS_W-1:0]   cfg_il_sel  = '0;
    logic [BLK_W-1:0]   shadow_table [ROWS*COLS];
    bit                 entry_written [ROWS*COLS];
    int unsigned        written_list [$];

    t_slot_result       expected_slots [$];

    // Idling control; both sides stop idling while idle_off is set.
    logic               idle_off  = 1'b0;
    int unsigned        hold_reqs = 0;
    int unsigned        hold_seen = 0;
    int unsigned        hold_left = 0;

    int unsigned        cycle_count = 0;
    int unsigned        err_count   = 0;
    int unsigned        n_writes    = 0;
    int unsigned        n_tokens    = 0;
    int unsigned        n_configs   = 0;
    int unsigned        n_local     = 0;
    int unsigned        n_oor       = 0;

    paged_kv_slot_mapper_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_slots.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Block size as the block uses it: zero reads as one, large values saturate.
    function automatic logic [BS_W-1:0] effective_bs();
        if (cfg_bs < BS_MIN)
            return BS_MIN;
        if (cfg_bs > BS_MAX)
            return BS_MAX;
        return cfg_bs;
    endfunction

    function automatic t_slot_result predict_slot(input logic [REQ_W-1:0] req,
                                                  input logic [POS_W-1:0] pos);
        t_slot_result    r;
        int unsigned     bs, il, vbs, col, voff, loff;
        longint unsigned prod;
        bs = effective_bs();
        case (cfg_il_sel)
            IL_SEL_1:  il = IL_LOG2_1;
            IL_SEL_16: il = IL_LOG2_16;
            default:   il = IL_LOG2_64;
        endcase
        vbs  = bs << cfg_ws_log2;
        col  = pos / vbs;
        voff = pos % vbs;
        // Chunks of the virtual block are dealt to the ranks in turn.
        r.local_hit = (((voff >> il) & ((1 << cfg_ws_log2) - 1)) == cfg_rank);
        loff        = ((voff >> (cfg_ws_log2 + il)) << il) + (voff & ((1 << il) - 1));
        r.oor       = (col >= COLS) || (req >= ROWS);
        r.slot      = PAD_SLOT;
        if (!r.oor && r.local_hit) begin
            prod   = longint'(shadow_table[int'(req) * COLS + col]) * bs + loff;
            r.slot = prod[SLOT_W-1:0];
        end
        return r;
    endfunction

    // Offers one transaction and updates the shadow state once it is taken.
    // The valid stays high on return so a following item can go back to back.
    task automatic send_item(input logic mode, input logic [REQ_W-1:0] req,
                             input logic [COL_W-1:0] col, input logic [BLK_W-1:0] blk,
                             input logic [POS_W-1:0] pos);
        int unsigned idx;
        while (!idle_off && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {pos, blk, col, req};
        i_s_tuser  <= mode;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        if (mode == MODE_TABLE) begin
            idx = int'(req) * COLS + col;
            shadow_table[idx] = blk;
            if (!entry_written[idx]) begin
                entry_written[idx] = 1'b1;
                written_list.push_back(idx);
            end
            n_writes++;
        end else begin
            expected_slots.push_back(predict_slot(req, pos));
            n_tokens++;
        end
    endtask

    task automatic write_entry(input logic [REQ_W-1:0] req, input logic [COL_W-1:0] col,
                               input logic [BLK_W-1:0] blk);
        send_item(MODE_TABLE, req, col, blk, POS_W'($urandom));
    endtask

    task automatic send_token(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos);
        send_item(MODE_TOKEN, req, COL_W'($urandom), BLK_W'($urandom), pos);
    endtask

    // Most tokens land on a written entry; the rest fall past the row end,
    // which never reads the table.
    task automatic send_random_token();
        int unsigned vbs, idx;
        vbs = effective_bs();
        vbs = vbs << cfg_ws_log2;
        if (written_list.size() != 0 && $urandom_range(99) < 85) begin
            idx = written_list[$urandom_range(written_list.size() - 1)];
            send_token(REQ_W'(idx / COLS), POS_W'((idx % COLS) * vbs + $urandom_range(vbs - 1)));
        end else begin
            send_token(REQ_W'($urandom), POS_W'($urandom_range(24'hFFFFFF, COLS * vbs)));
        end
    endtask

    task automatic send_random_item();
        if ($urandom_range(99) < 25)
            write_entry(REQ_W'($urandom), COL_W'($urandom), BLK_W'($urandom));
        else
            send_random_token();
    endtask

    // Drops the input valid and waits until every result is back, plus the
    // pipeline depth, since table writes in flight give no result to wait for.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (expected_slots.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_cfg(input int unsigned bs, input int unsigned wsl,
                             input int unsigned rk, input int unsigned ils);
        wait_idle();
        cfg_bs      = BS_W'(bs);
        cfg_ws_log2 = WSL_W'(wsl);
        cfg_rank    = RANK_W'(rk);
        cfg_il_sel  = ILS_W'(ils);
        n_configs++;
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_BLOCK_SIZE;
        i_cfg_wdata <= CFG_DATA_W'(cfg_bs);
        @(posedge i_clk);
        i_cfg_idx   <= CFG_WORLD_LOG2;
        i_cfg_wdata <= CFG_DATA_W'(cfg_ws_log2);
        @(posedge i_clk);
        i_cfg_idx   <= CFG_RANK;
        i_cfg_wdata <= CFG_DATA_W'(cfg_rank);
        @(posedge i_clk);
        i_cfg_idx   <= CFG_INTERLEAVE;
        i_cfg_wdata <= CFG_DATA_W'(cfg_il_sel);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Field extremes and the corner cases of the mapping, starting from the
    // reset configuration (block size 16, one rank, chunk of one token).
    task automatic test_directed();
        write_entry(6'd0, 6'd0, 20'h00000);
        write_entry(6'd0, 6'd1, 20'h00001);
        write_entry(6'd63, 6'd63, 20'hFFFFF);
        write_entry(6'd5, 6'd1, 20'hABCDE);
        send_token(6'd0, 24'd0);
        send_token(6'd0, 24'd15);
        send_token(6'd0, 24'd16);
        send_token(6'd63, 24'(63 * 16 + 15));
        send_token(6'd5, 24'd1024);              // first column past the row
        send_token(6'd0, 24'hFFFFFF);
        // Zero block size reads as one, select code 3 as 64-token chunks.
        apply_cfg(0, 3, 7, IL_SEL_64_ALIAS);
        send_token(6'd0, 24'd7);
        send_token(6'd63, 24'(63 * 8 + 7));
        send_token(6'd5, 24'd512);
        // Block size saturates at 1024; a rank above the rank count is never local.
        apply_cfg(2047, 1, 3, IL_SEL_16);
        send_token(6'd0, 24'd2047);
        send_token(6'd0, 24'(2048 + 20));
        // Largest virtual block; the last token gives the largest slot.
        apply_cfg(1024, 3, 7, IL_SEL_1);
        send_token(6'd0, 24'd7);
        send_token(6'd63, 24'(63 * 8192 + 8191));
    endtask

    task automatic test_config_sweep();
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: apply_cfg(1, 0, 0, IL_SEL_1);
                1: apply_cfg(1024, 3, 7, IL_SEL_64);
                2: apply_cfg(16, 2, 1, IL_SEL_16);
                3: apply_cfg(2047, 1, 1, IL_SEL_64_ALIAS);
                4: apply_cfg(0, 3, 5, IL_SEL_1);
                default: apply_cfg($urandom_range(2047), $urandom_range(3),
                                   $urandom_range(7), $urandom_range(3));
            endcase
            repeat (ITEMS_PER_PHASE) send_random_item();
        end
    endtask

    // Full rate on both streams for a long stretch.
    task automatic test_back_to_back();
        apply_cfg(64, 2, 2, IL_SEL_16);
        idle_off <= 1'b1;
        repeat (250) send_random_item();
        idle_off <= 1'b0;
    endtask

    // The receiver holds off for a long time while tokens keep coming, so the
    // queue fills and the input stalls until the output drains.
    task automatic test_output_stall();
        apply_cfg(32, 1, 0, IL_SEL_1);
        idle_off  <= 1'b1;
        hold_reqs <= hold_reqs + 1;
        repeat (80) send_random_token();
        idle_off  <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen  <= hold_reqs;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (idle_off) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Every result transaction is matched against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_slot_result want;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            if (expected_slots.size() == 0) begin
                $error("unexpected result: slot %0h, tuser %b", o_m_tdata, o_m_tuser);
                err_count++;
            end else begin
                want = expected_slots.pop_front();
                if (o_m_tdata[SLOT_W-1:0] !== want.slot) begin
                    $error("slot: expected %0h, got %0h", want.slot, o_m_tdata[SLOT_W-1:0]);
                    err_count++;
                end
                if (o_m_tuser[0] !== want.local_hit) begin
                    $error("local_hit: expected %b, got %b", want.local_hit, o_m_tuser[0]);
                    err_count++;
                end
                if (o_m_tuser[1] !== want.oor) begin
                    $error("out_of_range: expected %b, got %b", want.oor, o_m_tuser[1]);
                    err_count++;
                end
                n_local += want.local_hit;
                n_oor   += want.oor;
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_sweep();
        test_back_to_back();
        test_output_stall();
        wait_idle();
        if (expected_slots.size() != 0) begin
            $error("%0d expected results never arrived", expected_slots.size());
            err_count++;
        end
        $display("Ran %0d table writes and %0d token lookups over %0d configurations,",
                 n_writes, n_tokens, n_configs);
        $display("with %0d local results, %0d out of range, %0d mismatches.",
                 n_local, n_oor, err_count);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
